// ===== src/sll_pkg.sv =====
// Shared types, codes and defaults of the static linked list engine.
package sll_pkg;

  localparam int unsigned NODES_DEF      = 128;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STAT_W         = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOELEM = 2'd3;

  typedef enum logic [3:0] {
    S_RST_CLR,
    S_IDLE,
    S_START,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_DEL_A,
    S_DEL_B,
    S_GB_WALK,
    S_GB_LINK,
    S_CLR,
    S_DONE
  } sll_state_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_WALK_INIT,
    ACT_WALK_STEP,
    ACT_INS_START,
    ACT_INS_A,
    ACT_INS_B,
    ACT_DEL_START,
    ACT_DEL_A,
    ACT_GB_FRONT,
    ACT_GB_INIT,
    ACT_GB_STEP,
    ACT_GB_TAIL,
    ACT_GB_LINK,
    ACT_SWEEP
  } sll_act_e;

  typedef struct packed {
    sll_act_e          act;
    logic              set_st;
    logic [STAT_W-1:0] st;
    logic              load_out;
  } sll_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            walk_adv;
    logic            pos_ok;
    logic            nxt_zero;
    logic            free_empty;
    logic            gb_front;
    logic            gb_adv;
    logic            sweep_last;
    logic            out_free;
  } sll_status_t;

endpackage

// ===== src/sll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sll_ctrl.sv =====
// Controller state machine of the static linked list engine.
module sll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sll_pkg::sll_status_t sts_i,
  output sll_pkg::sll_cmd_t   cmd_o,
  output logic                in_ready_o
);
  import sll_pkg::*;

  sll_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RST_CLR: begin
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        case (sts_i.op) inside
          OP_INSERT, OP_DELETE: state_d = S_WALK;
          OP_CLEAR:             state_d = S_CLR;
          default:              state_d = S_DONE;
        endcase
      end
      S_WALK: begin
        if (sts_i.walk_adv) begin
          state_d = S_WALK;
        end else if (!sts_i.pos_ok) begin
          state_d = S_DONE;
        end else if (sts_i.op == OP_INSERT) begin
          state_d = sts_i.free_empty ? S_DONE : S_INS_A;
        end else begin
          state_d = sts_i.nxt_zero ? S_DONE : S_DEL_A;
        end
      end
      S_INS_A:   state_d = S_INS_B;
      S_INS_B:   state_d = S_DONE;
      S_DEL_A:   state_d = S_DEL_B;
      S_DEL_B:   state_d = sts_i.gb_front ? S_DONE : S_GB_WALK;
      S_GB_WALK: begin
        if (!sts_i.gb_adv) state_d = S_GB_LINK;
      end
      S_GB_LINK: state_d = S_DONE;
      S_CLR: begin
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '{act: ACT_NONE, set_st: 1'b0, st: STAT_OK, load_out: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_RST_CLR: cmd_o.act = ACT_SWEEP;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.act = ACT_CAPTURE;
      end
      S_START: begin
        case (sts_i.op) inside
          OP_INSERT, OP_DELETE: cmd_o.act = ACT_WALK_INIT;
          default:              cmd_o.act = ACT_NONE;
        endcase
      end
      S_WALK: begin
        if (sts_i.walk_adv) begin
          cmd_o.act = ACT_WALK_STEP;
        end else if (!sts_i.pos_ok) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = STAT_BADPOS;
        end else if (sts_i.op == OP_INSERT) begin
          if (sts_i.free_empty) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = STAT_NOFREE;
          end else begin
            cmd_o.act = ACT_INS_START;
          end
        end else begin
          if (sts_i.nxt_zero) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = STAT_NOELEM;
          end else begin
            cmd_o.act = ACT_DEL_START;
          end
        end
      end
      S_INS_A:   cmd_o.act = ACT_INS_A;
      S_INS_B:   cmd_o.act = ACT_INS_B;
      S_DEL_A:   cmd_o.act = ACT_DEL_A;
      S_DEL_B:   cmd_o.act = sts_i.gb_front ? ACT_GB_FRONT : ACT_GB_INIT;
      S_GB_WALK: cmd_o.act = sts_i.gb_adv ? ACT_GB_STEP : ACT_GB_TAIL;
      S_GB_LINK: cmd_o.act = ACT_GB_LINK;
      S_CLR:     cmd_o.act = ACT_SWEEP;
      S_DONE:    cmd_o.load_out = sts_i.out_free;
      default:   cmd_o.act = ACT_NONE;
    endcase
  end

endmodule

// ===== src/sll_datapath.sv =====
// Datapath of the static linked list engine: node memories, walk registers, result register.
module sll_datapath #(
  parameter int unsigned NODES      = sll_pkg::NODES_DEF,
  parameter int unsigned DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IW = $clog2(NODES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sll_pkg::sll_cmd_t              cmd_i,
  output sll_pkg::sll_status_t           sts_o,
  input  logic [sll_pkg::OP_W-1:0]       in_op_i,
  input  logic [sll_pkg::POS_W-1:0]      in_position_i,
  input  logic signed [DATA_WIDTH-1:0]   in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sll_pkg::STAT_W-1:0]     out_status_o,
  output logic signed [DATA_WIDTH-1:0]   out_removed_o
);
  import sll_pkg::*;

  logic [OP_W-1:0]              op_q, op_d;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic signed [DATA_WIDTH-1:0] val_q, val_d;
  logic [IW-1:0]                p_q, p_d;
  logic [POS_W-1:0]             j_q, j_d;
  logic [IW-1:0]                t_q, t_d;
  logic [IW-1:0]                n_q, n_d;
  logic [IW-1:0]                free_head_q, free_head_d;
  logic [IW-1:0]                k_q, k_d;
  logic [STAT_W-1:0]            st_q, st_d;
  logic signed [DATA_WIDTH-1:0] removed_q, removed_d;
  logic                         out_valid_q, out_valid_d;
  logic [STAT_W-1:0]            out_status_q, out_status_d;
  logic signed [DATA_WIDTH-1:0] out_removed_q, out_removed_d;

  logic                  link_we;
  logic [IW-1:0]         link_waddr, link_wdata, link_raddr, link_rdata;
  logic                  val_we;
  logic [DATA_WIDTH-1:0] val_rdata;
  logic [POS_W:0]        j_inc;
  logic                  sweep_last;

  sll_ram #(.WIDTH(IW), .DEPTH(NODES)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  // The value read address follows the link read data, which is the
  // node to be removed in the cycle that starts a delete.
  sll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(t_q),
    .wdata_i(val_q),
    .raddr_i(link_rdata),
    .rdata_o(val_rdata)
  );

  assign j_inc      = (POS_W + 1)'(j_q) + (POS_W + 1)'(1);
  assign sweep_last = (k_q == IW'(NODES - 1));

  always_comb begin
    sts_o.op         = op_q;
    sts_o.walk_adv   = (link_rdata != '0) && (j_inc < (POS_W + 1)'(pos_q));
    sts_o.pos_ok     = (j_inc == (POS_W + 1)'(pos_q));
    sts_o.nxt_zero   = (link_rdata == '0);
    sts_o.free_empty = (free_head_q == '0);
    sts_o.gb_front   = (free_head_q == '0) || (t_q < free_head_q);
    sts_o.gb_adv     = (link_rdata != '0) && (link_rdata < t_q);
    sts_o.sweep_last = sweep_last;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    op_d          = op_q;
    pos_d         = pos_q;
    val_d         = val_q;
    p_d           = p_q;
    j_d           = j_q;
    t_d           = t_q;
    n_d           = n_q;
    free_head_d   = free_head_q;
    k_d           = k_q;
    st_d          = cmd_i.set_st ? cmd_i.st : st_q;
    removed_d     = removed_q;
    link_we       = 1'b0;
    link_waddr    = '0;
    link_wdata    = '0;
    link_raddr    = '0;
    val_we        = 1'b0;

    case (cmd_i.act)
      ACT_CAPTURE: begin
        op_d      = in_op_i;
        pos_d     = in_position_i;
        val_d     = in_value_i;
        st_d      = STAT_OK;
        removed_d = '0;
      end
      ACT_WALK_INIT: begin
        p_d        = '0;
        j_d        = '0;
        link_raddr = '0;
      end
      ACT_WALK_STEP: begin
        p_d        = link_rdata;
        j_d        = j_inc[POS_W-1:0];
        link_raddr = link_rdata;
      end
      ACT_INS_START: begin
        t_d        = free_head_q;
        n_d        = link_rdata;
        link_raddr = free_head_q;
      end
      ACT_INS_A: begin
        free_head_d = link_rdata;
        link_we     = 1'b1;
        link_waddr  = t_q;
        link_wdata  = n_q;
        val_we      = 1'b1;
      end
      ACT_INS_B, ACT_GB_LINK: begin
        link_we    = 1'b1;
        link_waddr = p_q;
        link_wdata = t_q;
      end
      ACT_DEL_START: begin
        t_d        = link_rdata;
        link_raddr = link_rdata;
      end
      ACT_DEL_A: begin
        link_we    = 1'b1;
        link_waddr = p_q;
        link_wdata = link_rdata;
        removed_d  = val_rdata;
      end
      ACT_GB_FRONT: begin
        link_we     = 1'b1;
        link_waddr  = t_q;
        link_wdata  = free_head_q;
        free_head_d = t_q;
      end
      ACT_GB_INIT: begin
        p_d        = free_head_q;
        link_raddr = free_head_q;
      end
      ACT_GB_STEP: begin
        p_d        = link_rdata;
        link_raddr = link_rdata;
      end
      ACT_GB_TAIL: begin
        link_we    = 1'b1;
        link_waddr = t_q;
        link_wdata = link_rdata;
      end
      ACT_SWEEP: begin
        // Head and last node end their chains, every other node links on.
        link_we     = 1'b1;
        link_waddr  = k_q;
        link_wdata  = ((k_q == '0) || sweep_last) ? '0 : k_q + IW'(1);
        k_d         = sweep_last ? '0 : k_q + IW'(1);
        free_head_d = IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    if (cmd_i.load_out) begin
      out_valid_d   = 1'b1;
      out_status_d  = st_q;
      out_removed_d = removed_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= IW'(1);
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    p_q           <= p_d;
    j_q           <= j_d;
    t_q           <= t_d;
    n_q           <= n_d;
    st_q          <= st_d;
    removed_q     <= removed_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_removed_o = out_removed_q;

  // A node is only taken from a non-empty free chain, and it is the chain head.
  a_take_from_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_INS_A) |-> (free_head_q != '0) && (t_q == free_head_q))
    else $error("insert took a node that is not the free chain head");

  // The free chain stays ascending: a returned node goes after a smaller one.
  a_free_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_GB_LINK) |-> (p_q < t_q))
    else $error("freed node linked behind a larger index");

  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_SWEEP) && !sweep_last |=> (k_q == $past(k_q) + IW'(1)))
    else $error("chain rebuild skipped a node");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("result load did not raise the output valid");

endmodule

// ===== src/static_linked_list_engine.sv =====
// Top level of the static linked list engine: stream ports, controller and datapath.
//
// The engine keeps one index-linked list and one free chain in a fixed array of NODES
// nodes. Node 0 is the list head and never holds an element. Each request carries an
// operation in tuser (insert, delete or clear) and a 1-based position and a value in
// tdata; each request yields exactly one result with a status (ok, bad position, no free
// node, no element there) and the value removed by a successful delete, zero otherwise.
// Requests are handled one at a time. Timing is set by the single read port of the link
// memory, which the controller follows one link per cycle: insert and delete walk
// from the head to the predecessor of the position. A successful insert takes the
// head of the free chain and links it in. A successful delete unlinks the node and
// puts it at the front of the free chain when that chain is empty or starts at a
// larger index, and otherwise walks the free chain to put it back behind smaller
// free indices. An unused operation code changes nothing. Clear rewrites every link,
// one node a cycle. After reset the same rebuild runs with tready low. A finished
// result waits in an output register, so the next request is taken while it is still
// pending; a result that is still waiting when the next one is finished holds the
// engine until the receiver takes it.
module static_linked_list_engine #(
  parameter int unsigned NODES      = sll_pkg::NODES_DEF,
  parameter int unsigned DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IN_W  = ((sll_pkg::POS_W + DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((sll_pkg::STAT_W + DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata, from bit 0 up: position (8 bits), value (DATA_WIDTH bits, signed), zero fill.
  input  logic [IN_W-1:0]           s_axis_tdata,
  // tuser, from bit 0 up: op (2 bits).
  input  logic [sll_pkg::OP_W-1:0]  s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata, from bit 0 up: status (2 bits), removed_value (DATA_WIDTH bits, signed), zero fill.
  output logic [OUT_W-1:0]          m_axis_tdata
);
  import sll_pkg::*;

  sll_cmd_t    cmd;
  sll_status_t sts;

  logic signed [DATA_WIDTH-1:0] in_value;
  logic [STAT_W-1:0]            out_status;
  logic signed [DATA_WIDTH-1:0] out_removed;

  // The controller only sequences; every address, link and value lives in the datapath.
  sll_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  assign in_value = s_axis_tdata[POS_W +: DATA_WIDTH];

  sll_datapath #(
    .NODES     (NODES),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_position_i(s_axis_tdata[POS_W-1:0]),
    .in_value_i   (in_value),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_removed_o(out_removed)
  );

  // Status sits in the lowest bits, the removed value above it, zeros fill the rest.
  assign m_axis_tdata = OUT_W'({out_removed, out_status});

endmodule

// ===== tb/sv/tb_static_linked_list_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the static linked list engine with its list scoreboard.

typedef struct packed {
  logic [sll_pkg::STAT_W-1:0] status;
  logic [31:0]                removed;
} list_result_t;

class sll_scoreboard;
  localparam int unsigned NODE_CNT = sll_pkg::NODES_DEF;

  logic [31:0]  node_val [NODE_CNT];
  logic [7:0]   node_nxt [NODE_CNT];
  logic [7:0]   free_first;
  int unsigned  list_len;
  int unsigned  max_len;
  int unsigned  empty_frees;
  int unsigned  op_count [4];
  int unsigned  stat_count [4];
  int unsigned  errors;
  list_result_t pending_results [$];

  function new();
    errors      = 0;
    max_len     = 0;
    empty_frees = 0;
    list_len    = 0;
    foreach (node_val[k]) node_val[k] = '0;
    foreach (op_count[k]) op_count[k] = 0;
    foreach (stat_count[k]) stat_count[k] = 0;
    rebuild_chains();
  endfunction

  // Start-up chains: empty list at node 0, every other node free in ascending order.
  function void rebuild_chains();
    for (int k = 0; k < NODE_CNT; k++) begin
      node_nxt[k] = (k + 1 < NODE_CNT) ? 8'(k + 1) : 8'd0;
    end
    node_nxt[0] = 8'd0;
    free_first  = 8'd1;
  endfunction

  // Follows at most pos-1 links from the head and reports how many were taken.
  function logic [7:0] walk_to(input int unsigned pos, output int unsigned steps);
    logic [7:0]  p;
    int unsigned j;
    p = 8'd0;
    j = 0;
    while (node_nxt[p] != 8'd0 && j + 1 < pos && j < NODE_CNT) begin
      p = node_nxt[p];
      j++;
    end
    steps = j;
    return p;
  endfunction

  // Puts a node back so that the free chain stays sorted by index.
  function void give_back(input logic [7:0] t);
    logic [7:0]  p;
    int unsigned guard;
    p     = free_first;
    guard = 0;
    if (p == 8'd0 || t < p) begin
      node_nxt[t] = p;
      free_first  = t;
    end else begin
      while (node_nxt[p] != 8'd0 && node_nxt[p] < t && guard < NODE_CNT) begin
        p = node_nxt[p];
        guard++;
      end
      node_nxt[t] = node_nxt[p];
      node_nxt[p] = t;
    end
  endfunction

  function list_result_t predict_list_op(input logic [1:0] op, input logic [7:0] pos,
                                         input logic [31:0] val);
    list_result_t r;
    logic [7:0]   p;
    logic [7:0]   t;
    int unsigned  j;
    r.status  = sll_pkg::STAT_OK;
    r.removed = '0;
    case (op)
      sll_pkg::OP_INSERT: begin
        if (pos == 8'd0) begin
          r.status = sll_pkg::STAT_BADPOS;
        end else begin
          p = walk_to(pos, j);
          if (j + 1 != pos) begin
            r.status = sll_pkg::STAT_BADPOS;
          end else if (free_first == 8'd0) begin
            r.status = sll_pkg::STAT_NOFREE;
          end else begin
            t           = free_first;
            free_first  = node_nxt[t];
            node_val[t] = val;
            node_nxt[t] = node_nxt[p];
            node_nxt[p] = t;
            list_len++;
          end
        end
      end
      sll_pkg::OP_DELETE: begin
        if (pos == 8'd0) begin
          r.status = sll_pkg::STAT_BADPOS;
        end else begin
          p = walk_to(pos, j);
          if (j + 1 != pos) begin
            r.status = sll_pkg::STAT_BADPOS;
          end else begin
            t = node_nxt[p];
            if (t == 8'd0) begin
              r.status = sll_pkg::STAT_NOELEM;
            end else begin
              node_nxt[p] = node_nxt[t];
              r.removed   = node_val[t];
              if (free_first == 8'd0) empty_frees++;
              give_back(t);
              list_len--;
            end
          end
        end
      end
      sll_pkg::OP_CLEAR: begin
        rebuild_chains();
        list_len = 0;
      end
      default: begin
      end
    endcase
    if (list_len > max_len) max_len = list_len;
    return r;
  endfunction

  function void note_request(input logic [1:0] op, input logic [7:0] pos,
                             input logic [31:0] val);
    list_result_t r;
    r = predict_list_op(op, pos, val);
    pending_results.push_back(r);
    op_count[op]++;
    stat_count[r.status]++;
  endfunction

  function void check_result(input logic [1:0] status, input logic [31:0] removed);
    list_result_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, actual status %0d removed %0d",
               $time, status, $signed(removed));
      errors++;
    end else begin
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_r.status, status);
        errors++;
      end
      if (removed !== exp_r.removed) begin
        $display("%0t: removed value mismatch, expected %0d, actual %0d",
                 $time, $signed(exp_r.removed), $signed(removed));
        errors++;
      end
    end
  endfunction
endclass

module tb_static_linked_list_engine;

  localparam int unsigned NODES        = sll_pkg::NODES_DEF;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IN_W         = ((sll_pkg::POS_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_W        = ((sll_pkg::STAT_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 1550;
  // The list can hold every node but the head.
  localparam int unsigned LIST_CAP     = NODES - 1;
  // The one code of the op field that the engine does not define.
  localparam logic [sll_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Stimulus phases of the random part.
  typedef enum int {
    PH_GROW,
    PH_SHRINK,
    PH_MIXED,
    PH_NOISE,
    PH_CLEAR
  } phase_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_W-1:0]          s_axis_tdata  = '0;
  logic [sll_pkg::OP_W-1:0] s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_W-1:0]         m_axis_tdata;

  sll_scoreboard sb;

  // Sender burst state: requests left in the current burst.
  int unsigned burst_left = 0;

  // Receiver stall pattern: a style that is redrawn whenever its phase counter runs out.
  int unsigned rdy_style      = 0;
  int unsigned rdy_phase_left = 0;

  static_linked_list_engine #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The receiver alternates between always ready, mostly ready and mostly stalled, so
  // that back pressure lands on the output register holding a finished result and on
  // the engine as it waits to hand over the next one.
  always @(posedge clk_i) begin
    if (rdy_phase_left == 0) begin
      rdy_style      <= $urandom_range(2, 0);
      rdy_phase_left <= $urandom_range(400, 50);
    end else begin
      rdy_phase_left <= rdy_phase_left - 1;
    end
    case (rdy_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(3, 0) != 0);
      default: m_axis_tready <= ($urandom_range(7, 0) == 0);
    endcase
  end

  // Results are sampled at the rising edge, before any update of that edge lands, so
  // the handshake seen here is the one the engine sees.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[sll_pkg::STAT_W-1:0],
                      m_axis_tdata[sll_pkg::STAT_W +: DATA_W]);
    end
  end

  // Presents one request and holds it until accepted. The scoreboard predicts the
  // result at the accepting edge, so the list length it keeps is current when the next
  // request is chosen. At the end of a burst the sender drops tvalid for a random gap.
  task automatic send_request(input logic [sll_pkg::OP_W-1:0] op, input logic [7:0] pos,
                              input logic [DATA_W-1:0] val);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, pos};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, pos, val);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      // Now and then a long burst, so that some stretches run without gaps.
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(200, 60) :
                                                 $urandom_range(20, 1);
    end else begin
      burst_left--;
    end
  endtask

  // A request that need not make sense: any op, any position.
  task automatic send_noise();
    send_request(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), $urandom());
  endtask

  // An insert at a position that the current list accepts, or, at a full list, one that
  // runs into the empty free chain.
  task automatic send_good_insert();
    send_request(sll_pkg::OP_INSERT, 8'($urandom_range(sb.list_len + 1, 1)), $urandom());
  endtask

  // A delete of an element that is there; on an empty list this asks for position one.
  task automatic send_good_delete();
    if (sb.list_len == 0) begin
      send_request(sll_pkg::OP_DELETE, 8'd1, $urandom());
    end else begin
      send_request(sll_pkg::OP_DELETE, 8'($urandom_range(sb.list_len, 1)), $urandom());
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_items;
    int unsigned pick;
    phase_e      phase;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Position zero and positions past the end on the empty list, then
    // inserts of the extreme values at front, back and middle.
    send_request(sll_pkg::OP_INSERT, 8'd0, 32'h1234_5678);
    send_request(sll_pkg::OP_DELETE, 8'd0, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd1, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd2, 32'h0000_0000);
    send_request(sll_pkg::OP_INSERT, 8'd2, 32'h0000_0001);
    send_request(sll_pkg::OP_INSERT, 8'd1, 32'h7fff_ffff);
    send_request(sll_pkg::OP_INSERT, 8'd1, 32'h8000_0000);
    send_request(sll_pkg::OP_INSERT, 8'd3, 32'hffff_ffff);
    send_request(sll_pkg::OP_INSERT, 8'd2, 32'h0000_0000);
    // Four elements now: one past the append slot and the largest position fail.
    send_request(sll_pkg::OP_INSERT, 8'd6, 32'h0bad_0bad);
    send_request(sll_pkg::OP_INSERT, 8'd255, 32'hffff_ffff);
    // Delete at exactly length+1 finds no element; beyond that the position is bad.
    send_request(sll_pkg::OP_DELETE, 8'd5, 32'hffff_ffff);
    send_request(sll_pkg::OP_DELETE, 8'd255, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd4, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd1, 32'hffff_ffff);
    // The unused op code changes nothing; clear then leaves an empty list behind.
    send_request(OP_UNUSED, 8'd255, 32'hffff_ffff);
    send_request(sll_pkg::OP_CLEAR, 8'd0, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd1, 32'h0000_0000);
    send_request(sll_pkg::OP_INSERT, 8'd1, 32'h5555_5555);
    send_request(sll_pkg::OP_INSERT, 8'd2, 32'haaaa_aaaa);
    send_request(sll_pkg::OP_DELETE, 8'd2, 32'h0000_0000);
    send_request(sll_pkg::OP_DELETE, 8'd1, 32'h0000_0000);

    // Random part, in phases. Growth phases are long enough to fill the whole array,
    // which brings out the no-free-node answer and, on the next delete, the return of a
    // node into an empty free chain. Shrink and mixed phases walk a deep list and a
    // scattered free chain; noise and clears break the sequences up.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(9, 0);
      if (pick < 4) begin
        phase       = PH_GROW;
        phase_items = $urandom_range(160, 20);
      end else if (pick < 6) begin
        phase       = PH_SHRINK;
        phase_items = $urandom_range(130, 20);
      end else if (pick < 8) begin
        phase       = PH_MIXED;
        phase_items = $urandom_range(80, 30);
      end else if (pick < 9) begin
        phase       = PH_NOISE;
        phase_items = $urandom_range(30, 10);
      end else begin
        phase       = PH_CLEAR;
        phase_items = 1;
      end
      if (phase_items > RANDOM_ITEMS - sent) phase_items = RANDOM_ITEMS - sent;
      repeat (phase_items) begin
        pick = $urandom_range(19, 0);
        case (phase)
          PH_GROW: begin
            if (pick == 0) begin
              send_noise();
            end else if (pick == 1) begin
              // One past the append slot, or anything further out.
              send_request(sll_pkg::OP_INSERT, 8'($urandom_range(255, sb.list_len + 2)),
                           $urandom());
            end else begin
              send_good_insert();
            end
          end
          PH_SHRINK: begin
            if (pick == 0) begin
              send_noise();
            end else if (pick == 1) begin
              send_request(sll_pkg::OP_DELETE, 8'(sb.list_len + 1), $urandom());
            end else begin
              send_good_delete();
            end
          end
          PH_MIXED: begin
            if (pick == 0) begin
              send_noise();
            end else if (pick < 10) begin
              send_good_insert();
            end else begin
              send_good_delete();
            end
          end
          PH_NOISE: begin
            send_noise();
          end
          default: begin
            send_request(sll_pkg::OP_CLEAR, 8'($urandom_range(255, 0)), $urandom());
          end
        endcase
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    // Any result beyond the expected ones would surface within one full walk.
    repeat (2 * NODES + 16) @(posedge clk_i);

    $display("Ran %0d inserts, %0d deletes, %0d clears and %0d unused-code requests.",
             sb.op_count[sll_pkg::OP_INSERT], sb.op_count[sll_pkg::OP_DELETE],
             sb.op_count[sll_pkg::OP_CLEAR], sb.op_count[OP_UNUSED]);
    $display({"Answers ok/bad/full/none: %0d/%0d/%0d/%0d, longest list %0d of %0d, ",
              "%0d frees into an empty chain."},
             sb.stat_count[sll_pkg::STAT_OK], sb.stat_count[sll_pkg::STAT_BADPOS],
             sb.stat_count[sll_pkg::STAT_NOFREE], sb.stat_count[sll_pkg::STAT_NOELEM],
             sb.max_len, LIST_CAP, sb.empty_frees);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, with every request walking the
  // whole array twice and every result held back by the receiver.
  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
